// ===== hdl/rcc_pkg.sv =====
`default_nettype none

package rcc_pkg;

    localparam int DEFAULT_MAX_PERIOD = 1024;

    localparam int PERIOD_W = 11;
    localparam int FORGET_W = 17;
    localparam int LEARN_W  = 24;
    localparam int DRIVE_W  = 16;
    localparam int ERROR_W  = 16;
    localparam int CORR_W   = 24;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam logic [FORGET_W-1:0] FORGET_UNITY = 17'd65536;

    typedef enum logic [2:0] {
        REG_PERIOD    = 3'd0,
        REG_FORGET    = 3'd1,
        REG_LEARN     = 3'd2,
        REG_DRIVE_MIN = 3'd3,
        REG_DRIVE_MAX = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic        [FORGET_W-1:0] forget_gain;
        logic signed [LEARN_W-1:0]  learn_gain;
        logic signed [DRIVE_W-1:0]  drive_min;
        logic signed [DRIVE_W-1:0]  drive_max;
    } gains_t;

endpackage

`default_nettype wire

// ===== hdl/rcc_ram.sv =====
`default_nettype none

module rcc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rcc_datapath.sv =====
`default_nettype none

module rcc_datapath
    import rcc_pkg::*;
(
    input  wire gains_t                     gains,
    input  wire logic signed [CORR_W-1:0]   old_corr,
    input  wire logic signed [ERROR_W-1:0]  error_sample,
    input  wire logic signed [DRIVE_W-1:0]  base_drive,
    output logic signed [CORR_W-1:0]        new_corr,
    output logic signed [DRIVE_W-1:0]       drive
);

    logic signed [FORGET_W+CORR_W:0]          prod_forget;
    logic signed [LEARN_W+ERROR_W-1:0]        prod_learn;
    logic signed [FORGET_W+CORR_W+7:0]        acc;
    logic signed [FORGET_W+CORR_W-9:0]        acc_q8;
    logic signed [CORR_W:0]                   corr_rnd;
    logic signed [DRIVE_W:0]                  corr_int;
    logic signed [DRIVE_W+1:0]                sum;
    logic signed [DRIVE_W+1:0]                sum_hi;
    logic signed [DRIVE_W+1:0]                sum_lo;

    always_comb
    begin
        prod_forget = $signed({1'b0, gains.forget_gain}) * old_corr;
        prod_learn  = gains.learn_gain * error_sample;

        // Both terms carry 24 fractional bits; round half up back to 8.
        acc = (FORGET_W+CORR_W+8)'(prod_forget)
            + (FORGET_W+CORR_W+8)'($signed({prod_learn, 8'b0}))
            + (FORGET_W+CORR_W+8)'(32768);
        acc_q8 = acc[FORGET_W+CORR_W+7:16];

        if (acc_q8 > (FORGET_W+CORR_W-8)'(8388607))
        begin
            new_corr = {1'b0, {(CORR_W-1){1'b1}}};
        end
        else if (acc_q8 < -(FORGET_W+CORR_W-8)'(8388608))
        begin
            new_corr = {1'b1, {(CORR_W-1){1'b0}}};
        end
        else
        begin
            new_corr = acc_q8[CORR_W-1:0];
        end

        corr_rnd = (CORR_W+1)'(new_corr) + (CORR_W+1)'(128);
        corr_int = corr_rnd[CORR_W:8];
        sum      = (DRIVE_W+2)'(base_drive) + (DRIVE_W+2)'(corr_int);
        sum_hi   = (DRIVE_W+2)'(gains.drive_max);
        sum_lo   = (DRIVE_W+2)'(gains.drive_min);

        if (sum > sum_hi)
        begin
            sum = sum_hi;
        end
        if (sum < sum_lo)
        begin
            sum = sum_lo;
        end
        drive = sum[DRIVE_W-1:0];
    end

endmodule

`default_nettype wire

// ===== hdl/repetitive_control_correction_top.sv =====
`default_nettype none

// Channel      Direction  tdata (low bit up)                 tuser
// s_axis       in         error_sample[15:0], base_drive      error_invalid
// m_axis       out        drive[15:0]                         -
// apb          in/out     period, forget, learn, min, max     -
//
// An accepted item is registered while the ring memory reads its slot and the
// ring position advances; as it leaves, the correction is formed, written back
// and the drive lands in the output register. An error_invalid item skips the
// read, advance and write-back and repeats the last drive. One item per cycle
// is sustained unless the output stalls. After reset, and after any write that
// changes the period, the ring is cleared one slot per cycle, s_axis_tready low.

module repetitive_control_correction_top
    import rcc_pkg::*;
#(
    parameter int MAX_PERIOD = DEFAULT_MAX_PERIOD
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [31:0]            s_axis_tdata,  // error_sample, base_drive
    input  wire logic                   s_axis_tuser,  // error_invalid

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [DRIVE_W-1:0]          m_axis_tdata,  // drive

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

    logic [PERIOD_W-1:0]       period_reg, period_next;
    gains_t                    gains_reg, gains_next;
    logic [AW-1:0]             pos_reg, pos_next;
    logic                      clr_reg, clr_next;
    logic [AW-1:0]             clr_addr_reg, clr_addr_next;
    logic signed [DRIVE_W-1:0] last_drive_reg, last_drive_next;

    logic                      s1_valid_reg, s1_valid_next;
    logic                      s1_invalid_reg;
    logic [AW-1:0]             s1_addr_reg;
    logic signed [ERROR_W-1:0] s1_error_reg;
    logic signed [DRIVE_W-1:0] s1_base_reg;
    logic                      fwd_reg, fwd_next;
    logic signed [CORR_W-1:0]  fwd_data_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]        out_drive_reg;

    logic                      cfg_write;
    logic [PERIOD_W-1:0]       wr_period;
    logic [PERIOD_W-1:0]       eff_period;
    logic [FORGET_W-1:0]       wr_forget;
    logic                      s1_fire;
    logic                      accept;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [CORR_W-1:0]         ram_wdata;
    logic [CORR_W-1:0]         ram_rdata;
    logic signed [CORR_W-1:0]  old_corr;
    logic signed [CORR_W-1:0]  new_corr;
    logic signed [DRIVE_W-1:0] new_drive;

    rcc_ram #(
        .WIDTH (CORR_W),
        .DEPTH (MAX_PERIOD)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept && !s_axis_tuser),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign old_corr = fwd_reg ? fwd_data_reg : $signed(ram_rdata);

    rcc_datapath u_datapath (
        .gains        (gains_reg),
        .old_corr     (old_corr),
        .error_sample (s1_error_reg),
        .base_drive   (s1_base_reg),
        .new_corr     (new_corr),
        .drive        (new_drive)
    );

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_reg && (!s1_valid_reg || s1_fire);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drive_reg;

    assign wr_period = pwdata[PERIOD_W-1:0];
    assign wr_forget = pwdata[FORGET_W-1:0];

    always_comb
    begin
        if (wr_period == '0)
        begin
            eff_period = PERIOD_W'(1);
        end
        else if (32'(wr_period) > MAX_PERIOD)
        begin
            eff_period = PERIOD_W'(MAX_PERIOD);
        end
        else
        begin
            eff_period = wr_period;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = s1_addr_reg;
        ram_wdata = new_corr;
        if (clr_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (s1_fire && !s1_invalid_reg)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        period_next     = period_reg;
        gains_next      = gains_reg;
        pos_next        = pos_reg;
        clr_next        = clr_reg;
        clr_addr_next   = clr_addr_reg;
        last_drive_next = last_drive_reg;
        s1_valid_next   = s1_valid_reg;
        fwd_next        = fwd_reg;
        out_valid_next  = out_valid_reg;

        if (clr_reg)
        begin
            if (32'(clr_addr_reg) + 32'd1 >= 32'(period_reg))
            begin
                clr_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
            end
        end

        if (s1_fire && !s1_invalid_reg)
        begin
            last_drive_next = new_drive;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
            s1_valid_next  = 1'b0;
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
            fwd_next      = s1_fire && !s1_invalid_reg && (s1_addr_reg == pos_reg);
            if (!s_axis_tuser)
            begin
                if (32'(pos_reg) + 32'd1 >= 32'(period_reg))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + AW'(1);
                end
            end
        end

        if (cfg_write)
        begin
            case (reg_index_t'(paddr[4:2]))
                REG_PERIOD:
                begin
                    if (eff_period != period_reg)
                    begin
                        period_next   = eff_period;
                        pos_next      = '0;
                        clr_next      = 1'b1;
                        clr_addr_next = '0;
                    end
                end
                REG_FORGET:
                begin
                    gains_next.forget_gain = (wr_forget > FORGET_UNITY) ? FORGET_UNITY
                                                                        : wr_forget;
                end
                REG_LEARN:
                begin
                    gains_next.learn_gain = pwdata[LEARN_W-1:0];
                end
                REG_DRIVE_MIN:
                begin
                    gains_next.drive_min = pwdata[DRIVE_W-1:0];
                end
                REG_DRIVE_MAX:
                begin
                    gains_next.drive_max = pwdata[DRIVE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[4:2]))
            REG_PERIOD:    prdata = CFG_DATA_W'(period_reg);
            REG_FORGET:    prdata = CFG_DATA_W'(gains_reg.forget_gain);
            REG_LEARN:     prdata = CFG_DATA_W'($unsigned(gains_reg.learn_gain));
            REG_DRIVE_MIN: prdata = CFG_DATA_W'($unsigned(gains_reg.drive_min));
            REG_DRIVE_MAX: prdata = CFG_DATA_W'($unsigned(gains_reg.drive_max));
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg            <= PERIOD_W'(1);
            gains_reg.forget_gain <= FORGET_UNITY;
            gains_reg.learn_gain  <= '0;
            gains_reg.drive_min   <= {1'b1, {(DRIVE_W-1){1'b0}}};
            gains_reg.drive_max   <= {1'b0, {(DRIVE_W-1){1'b1}}};
            pos_reg               <= '0;
            clr_reg               <= 1'b1;
            clr_addr_reg          <= '0;
            last_drive_reg        <= '0;
            s1_valid_reg          <= 1'b0;
            fwd_reg               <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            period_reg     <= period_next;
            gains_reg      <= gains_next;
            pos_reg        <= pos_next;
            clr_reg        <= clr_next;
            clr_addr_reg   <= clr_addr_next;
            last_drive_reg <= last_drive_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_reg        <= fwd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_invalid_reg <= s_axis_tuser;
            s1_addr_reg    <= pos_reg;
            s1_error_reg   <= s_axis_tdata[ERROR_W-1:0];
            s1_base_reg    <= s_axis_tdata[ERROR_W+DRIVE_W-1:ERROR_W];
            fwd_data_reg   <= new_corr;
        end
        if (s1_fire)
        begin
            out_drive_reg <= s1_invalid_reg ? last_drive_reg : new_drive;
        end
    end

endmodule

`default_nettype wire
